/* design/ntv_pkg.sv */
// Shared constants, types and character classes for the numeric text validator.
package ntv_pkg;

	localparam int MAX_LEN = 32;
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int LEN_W   = $clog2(MAX_LEN + 1);

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef struct packed {
		logic             go;
		logic [LEN_W-1:0] len;
		logic             ovf;
	} ntv_start_t;

	typedef struct packed {
		logic ready;
		logic invalid;
		logic too_long;
	} ntv_verdict_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c inside {CH_SPACE, [CH_TAB:CH_CR]});
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c inside {[CH_ZERO:CH_NINE]});
	endfunction

	function automatic logic is_core(input logic [7:0] c);
		return is_dig(c) || (c inside {CH_COMMA, CH_DOT});
	endfunction

endpackage

/* design/numeric_text_validator_unit.sv */
// Numeric text validator: buffers a string and judges whether it is number text.
// Character requests are accepted without stall while the string loads.
// After the last request the scanner reads the n buffered characters twice, one read a
// cycle; an empty or overflowed string skips the reads and goes straight to the verdict.
// Requests stall until the verdict is taken; a verdict may wait in the output register.
// Reset clears length, overflow flag, control and output valid; the buffer is not cleared.
module numeric_text_validator_unit
	import ntv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       is_last,
	input  logic       is_empty,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       invalid,
	output logic       too_long
);

	logic             busy_q;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic             invalid_q;
	logic             too_long_q;

	logic             accept;
	logic             room;
	logic             wr_en;
	logic [LEN_W-1:0] len_d;
	logic             ovf_d;
	logic             take;
	logic [IDX_W-1:0] rd_addr;
	logic [7:0]       rd_data;
	ntv_start_t       start;
	ntv_verdict_t     verdict;

	assign in_stall  = busy_q;
	assign accept    = in_valid && !busy_q;
	assign room      = (len_q < LEN_W'(MAX_LEN));
	assign wr_en     = accept && !is_empty && room;
	assign len_d     = wr_en ? len_q + LEN_W'(1) : len_q;
	assign ovf_d     = ovf_q | (accept && !is_empty && !room);
	assign start.go  = accept && is_last;
	assign start.len = len_d;
	assign start.ovf = ovf_d;
	assign take      = verdict.ready && (!out_valid_q || !out_stall);

	ntv_text_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (len_q[IDX_W-1:0]),
		.wr_data (char_code),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ntv_scanner u_scanner (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.take    (take),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start.go) begin
				busy_q <= 1'b1;
				len_q  <= '0;
				ovf_q  <= 1'b0;
			end else if (accept) begin
				len_q <= len_d;
				ovf_q <= ovf_d;
			end
			if (take) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			invalid_q  <= verdict.invalid;
			too_long_q <= verdict.too_long;
		end
	end

	assign out_valid = out_valid_q;
	assign invalid   = invalid_q;
	assign too_long  = too_long_q;

endmodule

/* design/ntv_text_ram.sv */
// Character buffer memory with one write port and one registered read port.
module ntv_text_ram
	import ntv_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [7:0]       wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [7:0]       rd_data
);

	logic [7:0] mem [MAX_LEN];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* design/ntv_scanner.sv */
// Two-pass scan of the buffered string that forms the verdict.
module ntv_scanner
	import ntv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ntv_start_t       start,
	input  logic             take,
	output logic [IDX_W-1:0] rd_addr,
	input  logic [7:0]       rd_data,
	output ntv_verdict_t     verdict
);

	localparam logic [2:0] SC_IDLE  = 3'd0;
	localparam logic [2:0] SC_P1    = 3'd1;
	localparam logic [2:0] SC_P2    = 3'd2;
	localparam logic [2:0] SC_DRAIN = 3'd3;
	localparam logic [2:0] SC_FIN   = 3'd4;

	logic [2:0]       state_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic             ovf_q;
	logic             vld_s1;
	logic             pass2_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             nonws_q;
	logic             found_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;
	logic [IDX_W-1:0] first_q;
	logic [IDX_W-1:0] last_q;

	logic             dlr_q;
	logic             sign_q;
	logic             dec_q;
	logic             minus_q;
	logic             bad_q;
	logic [7:0]       prev_q;

	logic             dlr_d;
	logic             sign_d;
	logic             dec_d;
	logic             minus_d;
	logic             bad_d;
	logic [7:0]       prev_d;
	logic             p2_act;
	logic             last_issue;
	logic [LEN_W-1:0] cnt_inc;

	assign rd_addr    = cnt_q[IDX_W-1:0];
	assign cnt_inc    = cnt_q + LEN_W'(1);
	assign last_issue = (cnt_inc == len_q);
	assign p2_act     = vld_s1 && pass2_s1 && nonws_q && (idx_s1 >= lo_q) && (idx_s1 <= hi_q);

	always_comb begin
		dlr_d   = dlr_q;
		sign_d  = sign_q;
		dec_d   = dec_q;
		minus_d = minus_q;
		bad_d   = bad_q;
		prev_d  = prev_q;
		if (p2_act) begin
			if (!found_q || idx_s1 < first_q || idx_s1 > last_q) begin
				if (rd_data == CH_DOLLAR) begin
					bad_d = bad_q | dlr_q;
					dlr_d = 1'b1;
				end else if (rd_data inside {CH_PLUS, CH_MINUS}) begin
					bad_d  = bad_q | sign_q;
					sign_d = 1'b1;
				end else if (rd_data inside {CH_SPACE, CH_SLASH}) begin
					bad_d = bad_q;
				end else if (!found_q && rd_data == CH_COMMA) begin
					bad_d = bad_q;
				end else begin
					bad_d = 1'b1;
				end
			end else if (!(rd_data inside {CH_COMMA, CH_SLASH})) begin
				prev_d = rd_data;
				if (rd_data == CH_MINUS) begin
					minus_d = 1'b1;
					bad_d   = bad_q | (prev_q == CH_DOT);
				end else if (rd_data == CH_DOT) begin
					dec_d = 1'b1;
					bad_d = bad_q | dec_q | (prev_q == CH_MINUS);
				end else if (!is_dig(rd_data)) begin
					bad_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SC_IDLE;
			cnt_q    <= '0;
			vld_s1   <= 1'b0;
			pass2_s1 <= 1'b0;
		end else begin
			vld_s1   <= 1'b0;
			pass2_s1 <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (start.go) begin
						cnt_q   <= '0;
						state_q <= (start.ovf || start.len == '0) ? SC_FIN : SC_P1;
					end
				end
				SC_P1: begin
					vld_s1 <= 1'b1;
					if (last_issue) begin
						cnt_q   <= '0;
						state_q <= SC_P2;
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				SC_P2: begin
					vld_s1   <= 1'b1;
					pass2_s1 <= 1'b1;
					cnt_q    <= cnt_inc;
					if (last_issue) begin
						state_q <= SC_DRAIN;
					end
				end
				SC_DRAIN: begin
					state_q <= SC_FIN;
				end
				SC_FIN: begin
					if (take) begin
						state_q <= SC_IDLE;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (state_q == SC_IDLE && start.go) begin
			len_q   <= start.len;
			ovf_q   <= start.ovf;
			nonws_q <= 1'b0;
			found_q <= 1'b0;
			dlr_q   <= 1'b0;
			sign_q  <= 1'b0;
			dec_q   <= 1'b0;
			minus_q <= 1'b0;
			bad_q   <= 1'b0;
			prev_q  <= '0;
		end else begin
			if (vld_s1 && !pass2_s1) begin
				if (!is_ws(rd_data)) begin
					if (!nonws_q) begin
						lo_q <= idx_s1;
					end
					nonws_q <= 1'b1;
					hi_q    <= idx_s1;
				end
				if (is_core(rd_data)) begin
					if (!found_q) begin
						first_q <= idx_s1;
					end
					found_q <= 1'b1;
					last_q  <= idx_s1;
				end
			end
			dlr_q   <= dlr_d;
			sign_q  <= sign_d;
			dec_q   <= dec_d;
			minus_q <= minus_d;
			bad_q   <= bad_d;
			prev_q  <= prev_d;
		end
	end

	assign verdict.ready    = (state_q == SC_FIN);
	assign verdict.too_long = ovf_q;
	assign verdict.invalid  = ovf_q |
		(nonws_q & (bad_q | (minus_q & (dlr_q | sign_q))));

endmodule
